// ===== sv/drc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_pkg
// Types and constants shared by the dirty rectangle coalescer.
// ----------------------------------------------------------------------------
package drc_pkg;

   localparam int MAX_REGIONS_DEF = 16;
   localparam int COORD_BITS_DEF  = 32;
   localparam int RESULT_LIMIT    = 16;
   localparam int NUM_KINDS       = 5;
   localparam logic [4:0] CAP_RESET = 5'd16;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_UPDATE = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_READ   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [2:0]         item_kind;
      logic signed [31:0] rect_x;
      logic signed [31:0] rect_y;
      logic signed [31:0] rect_width;
      logic signed [31:0] rect_height;
      logic signed [31:0] second_x;
      logic signed [31:0] second_y;
      logic signed [31:0] second_width;
      logic signed [31:0] second_height;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [31:0] region_left;
      logic signed [31:0] region_top;
      logic signed [31:0] region_right;
      logic signed [31:0] region_bottom;
      logic               region_present;
      logic               last_of_run;
      logic [4:0]         count_now;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] left;
      logic signed [31:0] top;
      logic signed [31:0] right;
      logic signed [31:0] bottom;
   } box_type;

   function automatic logic box_touch(box_type a, box_type b);
      return (a.left <= b.right) && (b.left <= a.right) &&
             (a.top <= b.bottom) && (b.top <= a.bottom);
   endfunction

   function automatic box_type box_join(box_type a, box_type b);
      box_type r;
      r = a;
      if (b.left < a.left) r.left = b.left;
      if (b.top < a.top) r.top = b.top;
      if (b.right > a.right) r.right = b.right;
      if (b.bottom > a.bottom) r.bottom = b.bottom;
      return r;
   endfunction

   function automatic logic box_less(box_type a, box_type b);
      if (a.left != b.left) return a.left < b.left;
      if (a.top != b.top) return a.top < b.top;
      if (a.right != b.right) return a.right < b.right;
      return a.bottom < b.bottom;
   endfunction

endpackage

// ===== sv/drc_check_box.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_check_box
// Validates one rectangle and forms its edges; registered result.
// ----------------------------------------------------------------------------
module drc_check_box #(
   parameter int COORD_BITS = drc_pkg::COORD_BITS_DEF
) (
   input  logic               clock,
   input  logic signed [31:0] x,
   input  logic signed [31:0] y,
   input  logic signed [31:0] w,
   input  logic signed [31:0] h,
   output logic               ok_ff,
   output drc_pkg::box_type   box_ff
);

   localparam logic signed [32:0] HI = 33'sd1 <<< (COORD_BITS - 1);

   logic signed [32:0] right_w, bottom_w;
   logic               ok_in;

   always_comb begin
      right_w  = 33'(x) + 33'(w);
      bottom_w = 33'(y) + 33'(h);
      ok_in = !w[31] && !h[31] &&
              33'(x) < HI && 33'(x) >= -HI && 33'(y) < HI && 33'(y) >= -HI &&
              right_w < HI && bottom_w < HI;
   end

   always_ff @(posedge clock) begin
      ok_ff       <= ok_in;
      box_ff.left   <= x;
      box_ff.top    <= y;
      box_ff.right  <= right_w[31:0];
      box_ff.bottom <= bottom_w[31:0];
   end

endmodule

// ===== sv/drc_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_engine
// Region memory with read-modify-write sequencer: merge, append, collapse,
// insertion of the new region and readout, one memory access per step.
// ----------------------------------------------------------------------------
module drc_engine #(
   parameter int MAX_REGIONS = drc_pkg::MAX_REGIONS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       cmd,
   input  logic             ok,
   input  logic             two,
   input  drc_pkg::box_type box_a,
   input  drc_pkg::box_type box_b,
   input  logic [4:0]       cap,
   output logic             busy,
   output logic             out_valid,
   input  logic             out_ready,
   output drc_pkg::rsp_type out_item
);

   localparam int DEPTH = MAX_REGIONS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_REGIONS + 2);

   typedef enum logic [3:0] {
      S_IDLE, S_MRD, S_MCHK, S_SHRD, S_SHWR, S_APP, S_COLRD, S_COL, S_COLWR,
      S_SRD, S_SCMP, S_SFIN, S_RDRD, S_RDOUT, S_DONE
   } state_type;

   drc_pkg::box_type mem [DEPTH];
   drc_pkg::box_type rd_data;
   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   drc_pkg::box_type wr_data;

   state_type        state_ff;
   logic [CW-1:0]    count_ff, i_ff, j_ff;
   logic             again_ff, second_ff, ok_ff;
   drc_pkg::box_type merged_ff, box_b_ff;
   logic             out_valid_ff;
   drc_pkg::rsp_type out_ff;
   logic [CW-1:0]    cap_c;
   logic             out_free, emit;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end

   always_comb begin
      if (cap == 5'd0) cap_c = CW'(1);
      else if (32'(cap) > MAX_REGIONS) cap_c = CW'(MAX_REGIONS);
      else if (cap > 5'(drc_pkg::RESULT_LIMIT)) cap_c = CW'(drc_pkg::RESULT_LIMIT);
      else cap_c = CW'(cap);
   end

   always_comb begin
      out_free = !out_valid_ff || out_ready;
      emit = out_free && (state_ff == S_RDOUT || (state_ff == S_DONE && !second_ff));
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = j_ff[AW-1:0];
      wr_data = merged_ff;
      rd_addr = i_ff[AW-1:0];
      unique case (state_ff)
         S_SHRD: rd_addr = AW'(j_ff + CW'(1));
         S_SHWR: begin
            wr_en   = 1'b1;
            wr_data = rd_data;
         end
         S_APP: begin
            wr_en   = 1'b1;
            wr_addr = count_ff[AW-1:0];
         end
         S_COLWR: begin
            wr_en   = 1'b1;
            wr_addr = '0;
         end
         S_SRD: rd_addr = AW'(j_ff - CW'(1));
         S_SCMP: begin
            wr_en   = drc_pkg::box_less(merged_ff, rd_data);
            wr_data = rd_data;
         end
         S_SFIN: wr_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         again_ff     <= 1'b0;
         second_ff    <= 1'b0;
         ok_ff        <= 1'b0;
         merged_ff    <= '0;
         box_b_ff     <= '0;
         out_valid_ff <= 1'b0;
         out_ff       <= '0;
      end else begin
         out_valid_ff <= emit || (out_valid_ff && !out_ready);
         unique case (state_ff)
            S_IDLE: if (start) begin
               ok_ff <= ok || (cmd == drc_pkg::CMD_CLEAR);
               second_ff <= two && ok;
               merged_ff <= box_a;
               box_b_ff <= box_b;
               i_ff <= '0;
               again_ff <= 1'b0;
               if (cmd == drc_pkg::CMD_READ) state_ff <= S_RDRD;
               else if (cmd == drc_pkg::CMD_CLEAR) begin
                  count_ff <= '0;
                  state_ff <= S_DONE;
               end else if (ok) state_ff <= S_MRD;
               else state_ff <= S_DONE;
            end
            S_MRD: begin
               if (i_ff < count_ff) state_ff <= S_MCHK;
               else if (again_ff) begin
                  again_ff <= 1'b0;
                  i_ff <= '0;
               end else state_ff <= S_APP;
            end
            S_MCHK: begin
               if (drc_pkg::box_touch(merged_ff, rd_data)) begin
                  merged_ff <= drc_pkg::box_join(merged_ff, rd_data);
                  again_ff <= 1'b1;
                  j_ff <= i_ff;
                  state_ff <= S_SHRD;
               end else begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_MRD;
               end
            end
            S_SHRD: begin
               if (j_ff + CW'(1) < count_ff) state_ff <= S_SHWR;
               else begin
                  count_ff <= count_ff - CW'(1);
                  state_ff <= S_MRD;
               end
            end
            S_SHWR: begin
               j_ff <= j_ff + CW'(1);
               state_ff <= S_SHRD;
            end
            S_APP: begin
               count_ff <= count_ff + CW'(1);
               j_ff <= count_ff;
               if (count_ff + CW'(1) > cap_c) begin
                  i_ff <= '0;
                  state_ff <= S_COLRD;
               end else state_ff <= S_SRD;
            end
            S_COLRD: state_ff <= S_COL;
            S_COL: begin
               if (i_ff == '0) merged_ff <= rd_data;
               else merged_ff <= drc_pkg::box_join(merged_ff, rd_data);
               if (i_ff + CW'(1) == count_ff) state_ff <= S_COLWR;
               else begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_COLRD;
               end
            end
            S_COLWR: begin
               count_ff <= CW'(1);
               state_ff <= S_DONE;
            end
            S_SRD: begin
               if (j_ff == '0) state_ff <= S_SFIN;
               else state_ff <= S_SCMP;
            end
            S_SCMP: begin
               if (drc_pkg::box_less(merged_ff, rd_data)) begin
                  j_ff <= j_ff - CW'(1);
                  state_ff <= S_SRD;
               end else state_ff <= S_SFIN;
            end
            S_SFIN: state_ff <= S_DONE;
            S_RDRD: state_ff <= S_RDOUT;
            S_RDOUT: if (out_free) begin
               out_ff.accepted <= 1'b1;
               out_ff.count_now <= 5'(count_ff);
               if (count_ff == '0) begin
                  out_ff.region_present <= 1'b0;
                  out_ff.last_of_run <= 1'b1;
                  {out_ff.region_left, out_ff.region_top,
                   out_ff.region_right, out_ff.region_bottom} <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  out_ff.region_present <= 1'b1;
                  out_ff.region_left <= rd_data.left;
                  out_ff.region_top <= rd_data.top;
                  out_ff.region_right <= rd_data.right;
                  out_ff.region_bottom <= rd_data.bottom;
                  out_ff.last_of_run <= (i_ff + CW'(1) == count_ff);
                  i_ff <= i_ff + CW'(1);
                  state_ff <= (i_ff + CW'(1) == count_ff) ? S_IDLE : S_RDRD;
               end
            end
            S_DONE: begin
               if (second_ff) begin
                  second_ff <= 1'b0;
                  merged_ff <= box_b_ff;
                  i_ff <= '0;
                  again_ff <= 1'b0;
                  state_ff <= S_MRD;
               end else if (out_free) begin
                  out_ff.accepted <= ok_ff;
                  out_ff.count_now <= 5'(count_ff);
                  out_ff.region_present <= 1'b0;
                  out_ff.last_of_run <= 1'b1;
                  {out_ff.region_left, out_ff.region_top,
                   out_ff.region_right, out_ff.region_bottom} <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb busy = (state_ff != S_IDLE);
   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

endmodule

// ===== sv/dirty_rectangle_coalescer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rectangle_coalescer_core
// Dirty rectangle list with merge, cap collapse, sort and readout.
// An update runs two adds in turn. One item at a time: no new request is taken
// while the engine is busy. Read gives its regions one after another, and
// the result output holds each one while the receiver stalls.
// Synchronous reset clears the count and the cap returns to 16.
// ----------------------------------------------------------------------------
module dirty_rectangle_coalescer_core #(
   parameter int MAX_REGIONS = drc_pkg::MAX_REGIONS_DEF,
   parameter int COORD_BITS  = drc_pkg::COORD_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  drc_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output drc_pkg::rsp_type rsp_item,
   input  logic             csr_write,
   input  logic [4:0]       csr_wdata
);

   logic [4:0]       cap_ff;
   logic             busy, stage_ff;
   logic             ok_a, ok_b;
   drc_pkg::box_type box_a, box_b;
   logic [1:0]       cmd_ff;
   logic [2:0]       kind_ff;

   always_ff @(posedge clock) begin
      if (reset) cap_ff <= drc_pkg::CAP_RESET;
      else if (csr_write) cap_ff <= csr_wdata;
   end

   assign req_ready = !busy && !stage_ff;

   always_ff @(posedge clock) begin
      if (reset) stage_ff <= 1'b0;
      else stage_ff <= req_valid && req_ready;
      if (req_valid && req_ready) begin
         cmd_ff  <= req_item.cmd;
         kind_ff <= req_item.item_kind;
      end
   end

   drc_check_box #(.COORD_BITS(COORD_BITS)) u_chk_a (
      .clock, .x(req_item.rect_x), .y(req_item.rect_y),
      .w(req_item.rect_width), .h(req_item.rect_height),
      .ok_ff(ok_a), .box_ff(box_a));

   drc_check_box #(.COORD_BITS(COORD_BITS)) u_chk_b (
      .clock, .x(req_item.second_x), .y(req_item.second_y),
      .w(req_item.second_width), .h(req_item.second_height),
      .ok_ff(ok_b), .box_ff(box_b));

   drc_engine #(.MAX_REGIONS(MAX_REGIONS)) u_engine (
      .clock, .reset, .start(stage_ff), .cmd(cmd_ff),
      .ok(32'(kind_ff) < drc_pkg::NUM_KINDS && ok_a &&
          (cmd_ff != drc_pkg::CMD_UPDATE || ok_b)),
      .two(cmd_ff == drc_pkg::CMD_UPDATE), .box_a, .box_b, .cap(cap_ff),
      .busy, .out_valid(rsp_valid), .out_ready(rsp_ready), .out_item(rsp_item));

endmodule

// ===== sv/drc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drc_checker
// Port-level checks for the dirty rectangle coalescer.
// ----------------------------------------------------------------------------
module drc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input drc_pkg::rsp_type rsp_item
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("rsp item changed while stalled");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.count_now <= 5'd16)
      else $error("count above limit");

   a_present: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.region_present |-> rsp_item.accepted)
      else $error("region without accept");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("took second item while busy");

endmodule

bind dirty_rectangle_coalescer_core drc_checker u_drc_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_item);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, update, clear and read items into the dirty rectangle coalescer
// with random idling on both sides, predicts the region list in a scoreboard
// and checks every result item field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

   class region_scoreboard;
      drc_pkg::box_type regions[$];
      logic [4:0]       cap_reg;
      drc_pkg::rsp_type pending[$];
      int               errors;
      int               checked;

      function new();
         cap_reg = drc_pkg::CAP_RESET;
      endfunction

      function automatic int cap_now();
         int c;
         c = int'(cap_reg);
         if (c < 1) c = 1;
         if (c > drc_pkg::MAX_REGIONS_DEF) c = drc_pkg::MAX_REGIONS_DEF;
         if (c > drc_pkg::RESULT_LIMIT) c = drc_pkg::RESULT_LIMIT;
         return c;
      endfunction

      function automatic bit make_box(logic signed [31:0] x, logic signed [31:0] y,
                                      logic signed [31:0] w, logic signed [31:0] h,
                                      output drc_pkg::box_type b);
         longint r, bt;
         r  = longint'(x) + longint'(w);
         bt = longint'(y) + longint'(h);
         if (w < 0 || h < 0) return 0;
         if (r > 64'sd2147483647 || bt > 64'sd2147483647) return 0;
         b.left = x; b.top = y; b.right = r[31:0]; b.bottom = bt[31:0];
         return 1;
      endfunction

      function automatic bit overlap(drc_pkg::box_type a, drc_pkg::box_type b);
         return a.left <= b.right && b.left <= a.right &&
                a.top <= b.bottom && b.top <= a.bottom;
      endfunction

      function automatic drc_pkg::box_type grow(drc_pkg::box_type a,
                                                drc_pkg::box_type b);
         if (b.left < a.left) a.left = b.left;
         if (b.top < a.top) a.top = b.top;
         if (b.right > a.right) a.right = b.right;
         if (b.bottom > a.bottom) a.bottom = b.bottom;
         return a;
      endfunction

      function automatic bit precedes(drc_pkg::box_type a, drc_pkg::box_type b);
         if (a.left != b.left) return a.left < b.left;
         if (a.top != b.top) return a.top < b.top;
         if (a.right != b.right) return a.right < b.right;
         return a.bottom < b.bottom;
      endfunction

      function automatic void merge_in(drc_pkg::box_type m);
         bit again;
         int i, j;
         drc_pkg::box_type all, key;
         do begin
            again = 0;
            i = 0;
            while (i < regions.size()) begin
               if (overlap(m, regions[i])) begin
                  m = grow(m, regions[i]);
                  regions.delete(i);
                  again = 1;
               end else begin
                  i++;
               end
            end
         end while (again);
         regions.insert(regions.size(), m);
         if (regions.size() > cap_now()) begin
            all = regions[0];
            for (i = 1; i < regions.size(); i++) all = grow(all, regions[i]);
            regions = {all};
         end
         for (i = 1; i < regions.size(); i++) begin
            key = regions[i];
            j = i;
            while (j > 0 && precedes(key, regions[j-1])) begin
               regions[j] = regions[j-1];
               j--;
            end
            regions[j] = key;
         end
      endfunction

      function automatic void push_status(bit ok);
         drc_pkg::rsp_type r;
         r = '0;
         r.accepted = ok;
         r.last_of_run = 1;
         r.count_now = 5'(regions.size());
         pending.insert(pending.size(), r);
      endfunction

      function automatic void note_item(drc_pkg::req_type q);
         drc_pkg::box_type a, b;
         bit ok;
         drc_pkg::rsp_type r;
         int i;
         case (drc_pkg::cmd_type'(q.cmd))
            drc_pkg::CMD_READ: begin
               if (regions.size() == 0) push_status(1);
               for (i = 0; i < regions.size() && i < drc_pkg::RESULT_LIMIT; i++) begin
                  r = '0;
                  r.accepted = 1;
                  r.region_left = regions[i].left;
                  r.region_top = regions[i].top;
                  r.region_right = regions[i].right;
                  r.region_bottom = regions[i].bottom;
                  r.region_present = 1;
                  r.last_of_run = (i + 1 == regions.size()) ||
                                  (i + 1 == drc_pkg::RESULT_LIMIT);
                  r.count_now = 5'(regions.size());
                  pending.insert(pending.size(), r);
               end
            end
            drc_pkg::CMD_CLEAR: begin
               regions.delete();
               push_status(1);
            end
            drc_pkg::CMD_ADD: begin
               ok = q.item_kind < drc_pkg::NUM_KINDS &&
                    make_box(q.rect_x, q.rect_y, q.rect_width, q.rect_height, a);
               if (ok) merge_in(a);
               push_status(ok);
            end
            default: begin
               ok = q.item_kind < drc_pkg::NUM_KINDS &&
                    make_box(q.rect_x, q.rect_y, q.rect_width, q.rect_height, a) &&
                    make_box(q.second_x, q.second_y, q.second_width,
                             q.second_height, b);
               if (ok) begin
                  merge_in(a);
                  merge_in(b);
               end
               push_status(ok);
            end
         endcase
      endfunction

      task automatic report(string what);
         errors++;
         $display("mismatch @%0t: %s", $time, what);
      endtask

      task automatic check_item(drc_pkg::rsp_type got);
         drc_pkg::rsp_type e;
         if (pending.size() == 0) begin
            report($sformatf("unexpected result %p", got));
            return;
         end
         e = pending.pop_front();
         checked++;
         if (got.accepted !== e.accepted) report("accepted");
         if (got.region_left !== e.region_left) report("region_left");
         if (got.region_top !== e.region_top) report("region_top");
         if (got.region_right !== e.region_right) report("region_right");
         if (got.region_bottom !== e.region_bottom) report("region_bottom");
         if (got.region_present !== e.region_present) report("region_present");
         if (got.last_of_run !== e.last_of_run) report("last_of_run");
         if (got.count_now !== e.count_now)
            report($sformatf("count_now got %0d exp %0d", got.count_now, e.count_now));
      endtask
   endclass

   logic             clock, reset;
   logic             req_valid, req_ready, rsp_valid, rsp_ready;
   drc_pkg::req_type req_item;
   drc_pkg::rsp_type rsp_item;
   logic             csr_write;
   logic [4:0]       csr_wdata;

   region_scoreboard board;
   int  sent_items;
   int  idle_cycles;
   bit  hold_rsp;
   bit  quiet_rsp;

   dirty_rectangle_coalescer_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_item(rsp_item),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      board = new();
      reset = 1; req_valid = 0; req_item = '0; rsp_ready = 0;
      csr_write = 0; csr_wdata = '0;
      hold_rsp = 0; quiet_rsp = 0; sent_items = 0; idle_cycles = 0;
   end

   // check results and pace the receiver
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_item(rsp_item);
   end

   initial begin
      int gap;
      @(posedge clock);
      forever begin
         gap = quiet_rsp ? 0 : $urandom_range(0, 13);
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (600) @(posedge clock);
            hold_rsp = 0;
         end else if (gap > 0 && $urandom_range(0, 3) != 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_item(drc_pkg::req_type q, bit idle_ok);
      int gap;
      gap = idle_ok ? $urandom_range(0, 13) : 0;
      if (gap > 0 && $urandom_range(0, 2) != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_item <= q;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_item(q);
      sent_items++;
   endtask

   task automatic write_cap(logic [4:0] v);
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      csr_write <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 0;
      board.cap_reg = v;
   endtask

   function automatic logic [31:0] rnd_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000 | $urandom_range(0, 3);
         1: return 32'h7fff_ffff - $urandom_range(0, 3);
         2: return $urandom();
         default: return $urandom_range(0, 60);
      endcase
   endfunction

   function automatic logic [31:0] rnd_size();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return 32'hffff_ffff;
         2: return 0;
         default: return $urandom_range(0, 12);
      endcase
   endfunction

   function automatic drc_pkg::req_type rnd_req();
      drc_pkg::req_type q;
      int c;
      c = $urandom_range(0, 19);
      q.cmd = c < 11 ? drc_pkg::CMD_ADD : c < 15 ? drc_pkg::CMD_UPDATE :
              c < 16 ? drc_pkg::CMD_CLEAR : drc_pkg::CMD_READ;
      q.item_kind = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) :
                    3'($urandom_range(0, 4));
      q.rect_x = rnd_coord(); q.rect_y = rnd_coord();
      q.rect_width = rnd_size(); q.rect_height = rnd_size();
      q.second_x = rnd_coord(); q.second_y = rnd_coord();
      q.second_width = rnd_size(); q.second_height = rnd_size();
      return q;
   endfunction

   function automatic drc_pkg::req_type mk(drc_pkg::cmd_type c, int k, int x,
                                           int y, int w, int h);
      drc_pkg::req_type q;
      q = '0;
      q.cmd = c; q.item_kind = 3'(k);
      q.rect_x = x; q.rect_y = y; q.rect_width = w; q.rect_height = h;
      q.second_x = ~x; q.second_y = ~y; q.second_width = w; q.second_height = h;
      return q;
   endfunction

   initial begin
      drc_pkg::req_type q;
      int i, phase;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_item(mk(drc_pkg::CMD_READ, 0, 0, 0, 0, 0), 1);
      send_item(mk(drc_pkg::CMD_ADD, 0, 10, 10, 5, 5), 1);
      send_item(mk(drc_pkg::CMD_ADD, 4, 15, 15, 2, 2), 1);
      send_item(mk(drc_pkg::CMD_ADD, 1, 40, 0, 0, 0), 1);
      send_item(mk(drc_pkg::CMD_ADD, 5, 0, 0, 1, 1), 1);
      send_item(mk(drc_pkg::CMD_ADD, 7, 0, 0, 1, 1), 1);
      send_item(mk(drc_pkg::CMD_ADD, 2, 0, 0, 32'hffff_ffff, 1), 1);
      send_item(mk(drc_pkg::CMD_ADD, 2, 0, 0, 1, 32'h8000_0000), 1);
      send_item(mk(drc_pkg::CMD_ADD, 3, 32'h7fff_fff0, 0, 32'h10, 1), 1);
      send_item(mk(drc_pkg::CMD_ADD, 3, 32'h7fff_fff0, 0, 32'h0f, 1), 1);
      send_item(mk(drc_pkg::CMD_ADD, 3, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 0), 1);
      send_item(mk(drc_pkg::CMD_ADD, 3, 0, 32'h7fff_0000, 0, 32'h7fff_ffff), 1);
      send_item(mk(drc_pkg::CMD_READ, 0, 0, 0, 0, 0), 1);
      q = mk(drc_pkg::CMD_UPDATE, 0, 100, 100, 3, 3);
      q.second_x = 200; q.second_y = 200; q.second_width = 1; q.second_height = 1;
      send_item(q, 1);
      q.second_width = 32'hffff_ffff;
      send_item(q, 1);
      q = mk(drc_pkg::CMD_UPDATE, 6, 1, 1, 1, 1);
      send_item(q, 1);
      send_item(mk(drc_pkg::CMD_READ, 0, 0, 0, 0, 0), 1);
      send_item(mk(drc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 1);
      for (i = 0; i < 17; i++) send_item(mk(drc_pkg::CMD_ADD, 0, i * 4, 0, 1, 1), 0);
      send_item(mk(drc_pkg::CMD_READ, 0, 0, 0, 0, 0), 1);

      // long receiver hold-off while items keep coming
      hold_rsp = 1;
      for (i = 0; i < 6; i++) send_item(mk(drc_pkg::CMD_ADD, 1, i * 3, 50, 0, 0), 0);
      send_item(mk(drc_pkg::CMD_READ, 0, 0, 0, 0, 0), 0);

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_cap(5'd1);
            1: write_cap(5'd0);
            2: write_cap(5'd31);
            3: write_cap(5'($urandom_range(2, 15)));
            default: write_cap(5'd16);
         endcase
         quiet_rsp = (phase == 4);
         send_item(mk(drc_pkg::CMD_CLEAR, 0, 0, 0, 0, 0), 1);
         for (i = 0; i < 34; i++) send_item(rnd_req(), phase != 4);
         send_item(mk(drc_pkg::CMD_READ, 0, 0, 0, 0, 0), 1);
      end
      req_valid <= 0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      $display("Sent %0d items, checked %0d results over caps 1, 0, 31, mid and 16.",
               sent_items, board.checked);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
